@@ rtl/scm_pkg.sv @@
// ----------------------------------------------------------------------------
// scm_pkg
// Shared types, register indexes, opcodes and the trim/clamp function of the
// servo command mixer.
// ----------------------------------------------------------------------------
package scm_pkg;

	localparam int AXES       = 4;
	localparam int AXIS_IDX_W = $clog2(AXES);
	localparam int BYTE_W     = 8;
	localparam int TRIM_W     = 9;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int LEFT_W     = 3;

	localparam logic [BYTE_W-1:0] CONTROL_OPCODE = 8'd1;
	localparam logic [BYTE_W-1:0] PARTY_OPCODE   = 8'd2;

	localparam logic [BYTE_W-1:0] AXIS_RESET_MID = 8'd128;
	localparam logic [BYTE_W-1:0] CLAMP_MAX      = 8'd255;

	localparam logic [CFG_DATA_W-1:0] FALLBACK_VALUES_RST  = 32'h0080_8080;
	localparam logic [AXES-1:0]       FALLBACK_ENABLES_RST = 4'hF;
	localparam logic [CFG_DATA_W-1:0] CHANNEL_MAP_RST      = 32'h0403_0201;

	localparam logic [AXIS_IDX_W-1:0] AXIS_PITCH    = 2'd0;
	localparam logic [AXIS_IDX_W-1:0] AXIS_ROLL     = 2'd1;
	localparam logic [AXIS_IDX_W-1:0] AXIS_YAW      = 2'd2;
	localparam logic [AXIS_IDX_W-1:0] AXIS_THROTTLE = 2'd3;

	typedef enum logic [1:0] {
		MODE_CMD      = 2'd0,
		MODE_FALLBACK = 2'd1,
		MODE_REVERT   = 2'd2,
		MODE_UPDATE   = 2'd3
	} mode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PITCH_TRIM       = 3'd0,
		REG_ROLL_TRIM        = 3'd1,
		REG_YAW_TRIM         = 3'd2,
		REG_THROTTLE_TRIM    = 3'd3,
		REG_FALLBACK_VALUES  = 3'd4,
		REG_FALLBACK_ENABLES = 3'd5,
		REG_CHANNEL_MAP      = 3'd6
	} cfg_reg_t;

	typedef struct packed {
		logic [AXES-1:0][TRIM_W-1:0] trim;
		logic [AXES-1:0][BYTE_W-1:0] fallback_values;
		logic [AXES-1:0]             fallback_enables;
		logic [AXES-1:0][BYTE_W-1:0] channel_map;
	} cfg_t;

	typedef struct packed {
		logic [AXES-1:0][BYTE_W-1:0] value;
		logic                        fallback;
	} axis_state_t;

	// value minus signed trim, clamped to 0..255
	function automatic logic [BYTE_W-1:0] trim_clamp(input logic [BYTE_W-1:0] v,
			input logic [TRIM_W-1:0] trim);
		logic signed [TRIM_W:0] t;
		t = $signed({2'b00, v}) - $signed({trim[TRIM_W-1], trim});
		if (t < 0) begin
			return '0;
		end else if (t > $signed({2'b00, CLAMP_MAX})) begin
			return CLAMP_MAX;
		end else begin
			return t[BYTE_W-1:0];
		end
	endfunction

endpackage

@@ rtl/scm_cmd_if.sv @@
// ----------------------------------------------------------------------------
// scm_cmd_if
// Command event channel: mode and command byte with valid/ready.
// ----------------------------------------------------------------------------
interface scm_cmd_if;
	import scm_pkg::*;

	logic              valid;
	logic              ready;
	mode_t             mode;
	logic [BYTE_W-1:0] data_byte;

	modport source (output valid, mode, data_byte, input ready);
	modport sink   (input valid, mode, data_byte, output ready);
endinterface

@@ rtl/scm_res_if.sv @@
// ----------------------------------------------------------------------------
// scm_res_if
// Servo result channel: channel, target value and flags with valid/ready.
// ----------------------------------------------------------------------------
interface scm_res_if;
	import scm_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] servo_channel;
	logic [BYTE_W-1:0] target_value;
	logic              in_fallback;
	logic              last;

	modport source (output valid, servo_channel, target_value, in_fallback, last,
		input ready);
	modport sink   (input valid, servo_channel, target_value, in_fallback, last,
		output ready);
endinterface

@@ rtl/servo_command_mixer.sv @@
// ----------------------------------------------------------------------------
// servo_command_mixer
// Four-axis servo command mixer: command bytes, fallback and update events in,
// trimmed servo targets out.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one event per transaction: a command byte, enter fallback,
//   revert or update. Command, fallback and revert events take effect at the
//   accepting edge, one per cycle, and produce no result.
//   An update captures the four trimmed axis values at its accepting edge;
//   res presents them the next cycle, pitch, roll, yaw, throttle, one per
//   transaction, with last set on throttle.
//   Non-update events keep flowing while results drain. A further update is
//   held off (cmd.ready low) until the throttle result of the previous one is
//   taken; it may be accepted in that same cycle.
//   When res stalls, the current result holds and only updates back up.
//   Reset clears the pending result flag, the pending payload count and the
//   fallback flag, sets pitch, roll and yaw to 128, throttle to 0, and loads the
//   register defaults. Write cfg only while the block is idle.
// ----------------------------------------------------------------------------
module servo_command_mixer (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [scm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [scm_pkg::CFG_DATA_W-1:0]  cfg_data,
	scm_cmd_if.sink                         cmd,
	scm_res_if.source                       res
);
	import scm_pkg::*;

	cfg_t        cfg;
	axis_state_t state;
	logic        bank_free;
	logic        cmd_fire;
	logic        load;

	assign cmd.ready = (cmd.mode != MODE_UPDATE) || bank_free;
	assign cmd_fire  = cmd.valid && cmd.ready;
	assign load      = cmd_fire && (cmd.mode == MODE_UPDATE);

	scm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	scm_axis_state u_axis (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (cmd_fire),
		.mode      (cmd.mode),
		.data_byte (cmd.data_byte),
		.cfg       (cfg),
		.state     (state)
	);

	scm_result_queue u_res (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (load),
		.state  (state),
		.cfg    (cfg),
		.free   (bank_free),
		.res    (res)
	);

`ifndef SYNTHESIS
	a_update_only_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready && cmd.mode == MODE_UPDATE) |->
		(!res.valid || (res.ready && res.last)))
		else $error("update accepted while results still pending");

	a_update_starts_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready && cmd.mode == MODE_UPDATE) |=>
		(res.valid && !res.last))
		else $error("update did not start a fresh result burst");

	a_burst_continues: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.ready && !res.last) |=> res.valid)
		else $error("result burst ended before throttle");
`endif

endmodule

@@ rtl/scm_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// scm_cfg_regs
// Configuration register file: trims, fallback values and enables, channel map.
// ----------------------------------------------------------------------------
module scm_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [scm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [scm_pkg::CFG_DATA_W-1:0]   cfg_data,
	output scm_pkg::cfg_t                    cfg
);
	import scm_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.trim             <= '0;
			cfg_q.fallback_values  <= FALLBACK_VALUES_RST;
			cfg_q.fallback_enables <= FALLBACK_ENABLES_RST;
			cfg_q.channel_map      <= CHANNEL_MAP_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_PITCH_TRIM:       cfg_q.trim[AXIS_PITCH]    <= cfg_data[TRIM_W-1:0];
				REG_ROLL_TRIM:        cfg_q.trim[AXIS_ROLL]     <= cfg_data[TRIM_W-1:0];
				REG_YAW_TRIM:         cfg_q.trim[AXIS_YAW]      <= cfg_data[TRIM_W-1:0];
				REG_THROTTLE_TRIM:    cfg_q.trim[AXIS_THROTTLE] <= cfg_data[TRIM_W-1:0];
				REG_FALLBACK_VALUES:  cfg_q.fallback_values     <= cfg_data;
				REG_FALLBACK_ENABLES: cfg_q.fallback_enables    <= cfg_data[AXES-1:0];
				REG_CHANNEL_MAP:      cfg_q.channel_map         <= cfg_data;
				default: begin
					// drop writes to unmapped indexes
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

@@ rtl/scm_axis_state.sv @@
// ----------------------------------------------------------------------------
// scm_axis_state
// Command byte decoder and axis value state: control payload, party opcode,
// fallback entry and revert.
// ----------------------------------------------------------------------------
module scm_axis_state (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  scm_pkg::mode_t              mode,
	input  logic [scm_pkg::BYTE_W-1:0]  data_byte,
	input  scm_pkg::cfg_t               cfg,
	output scm_pkg::axis_state_t        state
);
	import scm_pkg::*;

	axis_state_t            state_q, state_d;
	logic [LEFT_W-1:0]      left_q, left_d;
	logic [LEFT_W-1:0]      slot;

	// payload slot: four left -> pitch, one left -> throttle
	assign slot = LEFT_W'(AXES) - left_q;

	always_comb begin
		state_d = state_q;
		left_d  = left_q;
		if (accept) begin
			case (mode)
				MODE_CMD: begin
					if (left_q != '0) begin
						state_d.value[slot[AXIS_IDX_W-1:0]] = data_byte;
						left_d = left_q - 1'b1;
					end else if (data_byte == CONTROL_OPCODE) begin
						left_d = LEFT_W'(AXES);
					end else if (data_byte == PARTY_OPCODE) begin
						state_d.value[AXIS_YAW] = '0;
					end
				end
				MODE_FALLBACK: begin
					// load only on entry
					if (!state_q.fallback) begin
						state_d.fallback = 1'b1;
						for (int k = 0; k < AXES; k++) begin
							if (cfg.fallback_enables[k]) begin
								state_d.value[k] = cfg.fallback_values[k];
							end
						end
					end
				end
				MODE_REVERT: state_d.fallback = 1'b0;
				default: begin
					// update events leave the state alone
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.value[AXIS_PITCH]    <= AXIS_RESET_MID;
			state_q.value[AXIS_ROLL]     <= AXIS_RESET_MID;
			state_q.value[AXIS_YAW]      <= AXIS_RESET_MID;
			state_q.value[AXIS_THROTTLE] <= '0;
			state_q.fallback             <= 1'b0;
			left_q                       <= '0;
		end else begin
			state_q <= state_d;
			left_q  <= left_d;
		end
	end

	assign state = state_q;

endmodule

@@ rtl/scm_result_queue.sv @@
// ----------------------------------------------------------------------------
// scm_result_queue
// Result register bank: captures the four trimmed axis results of an update
// and hands them out one per transaction, pitch first, throttle last.
// ----------------------------------------------------------------------------
module scm_result_queue (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  scm_pkg::axis_state_t  state,
	input  scm_pkg::cfg_t         cfg,
	output logic                  free,
	scm_res_if.source             res
);
	import scm_pkg::*;

	logic [AXES-1:0][BYTE_W-1:0] chan_q;
	logic [AXES-1:0][BYTE_W-1:0] value_q;
	logic                        fb_q;
	logic [AXIS_IDX_W-1:0]       idx_q;
	logic                        pend_q;
	logic                        take;
	logic                        take_last;

	assign take      = res.valid && res.ready;
	assign take_last = take && (idx_q == AXIS_THROTTLE);
	assign free      = !pend_q || take_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			idx_q  <= '0;
		end else if (load) begin
			pend_q <= 1'b1;
			idx_q  <= '0;
		end else if (take) begin
			idx_q <= idx_q + 1'b1;
			if (take_last) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			for (int k = 0; k < AXES; k++) begin
				chan_q[k]  <= cfg.channel_map[k];
				value_q[k] <= trim_clamp(state.value[k], cfg.trim[k]);
			end
			fb_q <= state.fallback;
		end
	end

	assign res.valid         = pend_q;
	assign res.servo_channel = chan_q[idx_q];
	assign res.target_value  = value_q[idx_q];
	assign res.in_fallback   = fb_q;
	assign res.last          = (idx_q == AXIS_THROTTLE);

endmodule

@@ dv/servo_target_checker.sv @@
// ----------------------------------------------------------------------------
// servo_target_checker
// Watches the command, result and register ports of the servo command mixer.
// Keeps its own copy of the axis values, the fallback flag and the registers,
// works out the four servo targets of every accepted update and compares
// each result transaction against the oldest target still due.
// ----------------------------------------------------------------------------
module servo_target_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [scm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [scm_pkg::CFG_DATA_W-1:0]  cfg_data,
	scm_cmd_if                              cmd,
	scm_res_if                              res,
	output int                              targets_pending,
	output int                              mismatch_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import scm_pkg::*;

	typedef struct packed {
		logic [BYTE_W-1:0] servo_channel;
		logic [BYTE_W-1:0] target_value;
		logic              in_fallback;
		logic              last;
	} servo_target_t;

	logic [AXES-1:0][TRIM_W-1:0] trim_reg;
	logic [AXES-1:0][BYTE_W-1:0] fb_values;
	logic [AXES-1:0]             fb_enables;
	logic [AXES-1:0][BYTE_W-1:0] chan_map;

	logic [AXES-1:0][BYTE_W-1:0] axis_val;
	logic [LEFT_W-1:0]           bytes_due;
	logic                        fb_on;

	servo_target_t targets_due[$];
	int            fails;

	function automatic logic [BYTE_W-1:0] trimmed_target(input logic [BYTE_W-1:0] v,
			input logic [TRIM_W-1:0] t);
		int diff;
		diff = int'(v) - (int'(t) - (t[TRIM_W-1] ? (1 << TRIM_W) : 0));
		if (diff < 0) begin
			diff = 0;
		end else if (diff > int'(CLAMP_MAX)) begin
			diff = int'(CLAMP_MAX);
		end
		return diff[BYTE_W-1:0];
	endfunction

	task automatic compare_field(input string field, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			fails++;
		end
	endtask

	task automatic check_target();
		servo_target_t want;
		if (targets_due.size() == 0) begin
			$error("result with no update waiting: servo_channel %0d target_value %0d",
				res.servo_channel, res.target_value);
			fails++;
		end else begin
			want = targets_due.pop_front();
			compare_field("servo_channel", want.servo_channel, res.servo_channel);
			compare_field("target_value", want.target_value, res.target_value);
			compare_field("in_fallback", want.in_fallback, res.in_fallback);
			compare_field("last", want.last, res.last);
		end
	endtask

	task automatic load_reg();
		case (cfg_reg_t'(cfg_index))
			REG_PITCH_TRIM, REG_ROLL_TRIM, REG_YAW_TRIM, REG_THROTTLE_TRIM: begin
				trim_reg[cfg_index[AXIS_IDX_W-1:0]] = cfg_data[TRIM_W-1:0];
			end
			REG_FALLBACK_VALUES: begin
				fb_values = cfg_data;
			end
			REG_FALLBACK_ENABLES: begin
				fb_enables = cfg_data[AXES-1:0];
			end
			REG_CHANNEL_MAP: begin
				chan_map = cfg_data;
			end
			default: begin
			end
		endcase
	endtask

	task automatic mix_command(input mode_t m, input logic [BYTE_W-1:0] b);
		int k;
		servo_target_t t;
		case (m)
			MODE_CMD: begin
				// a pending payload byte is never decoded as an opcode
				if (bytes_due != 0) begin
					axis_val[AXES - int'(bytes_due)] = b;
					bytes_due = bytes_due - 1'b1;
				end else if (b == CONTROL_OPCODE) begin
					bytes_due = LEFT_W'(AXES);
				end else if (b == PARTY_OPCODE) begin
					axis_val[AXIS_YAW] = '0;
				end
			end
			MODE_FALLBACK: begin
				// load only on entry
				if (!fb_on) begin
					fb_on = 1'b1;
					for (k = 0; k < AXES; k++) begin
						if (fb_enables[k]) begin
							axis_val[k] = fb_values[k];
						end
					end
				end
			end
			MODE_REVERT: begin
				fb_on = 1'b0;
			end
			MODE_UPDATE: begin
				for (k = 0; k < AXES; k++) begin
					t.servo_channel = chan_map[k];
					t.target_value  = trimmed_target(axis_val[k], trim_reg[k]);
					t.in_fallback   = fb_on;
					t.last          = (k == AXES - 1);
					targets_due.push_back(t);
				end
			end
			default: begin
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trim_reg        = '0;
			fb_values       = FALLBACK_VALUES_RST;
			fb_enables      = FALLBACK_ENABLES_RST;
			chan_map        = CHANNEL_MAP_RST;
			axis_val[AXIS_PITCH]    = AXIS_RESET_MID;
			axis_val[AXIS_ROLL]     = AXIS_RESET_MID;
			axis_val[AXIS_YAW]      = AXIS_RESET_MID;
			axis_val[AXIS_THROTTLE] = '0;
			bytes_due       = '0;
			fb_on           = 1'b0;
			fails           = 0;
			targets_due.delete();
			targets_pending <= 0;
			mismatch_count  <= 0;
		end else begin
			if (res.valid && res.ready) begin
				check_target();
			end
			if (cfg_we) begin
				load_reg();
			end
			if (cmd.valid && cmd.ready) begin
				mix_command(cmd.mode, cmd.data_byte);
			end
			targets_pending <= targets_due.size();
			mismatch_count  <= fails;
		end
	end

endmodule

@@ dv/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Stimulus for the servo command mixer: a directed run through opcodes,
// payload corner cases and fallback handling, then random command streams
// under several register settings, with random gaps on both channels.
// Checking is done by servo_target_checker beside the block.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import scm_pkg::*;

	localparam int RANDOM_PER_PHASE = 26;
	localparam int MAX_WAIT         = 18;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	int                    targets_pending;
	int                    mismatch_count;
	bit                    send_steady;
	bit                    take_steady;

	scm_cmd_if cmd_ch();
	scm_res_if res_ch();

	servo_command_mixer u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd_ch),
		.res       (res_ch)
	);

	servo_target_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.cmd             (cmd_ch),
		.res             (res_ch),
		.targets_pending (targets_pending),
		.mismatch_count  (mismatch_count)
	);

	always #10 clk = ~clk;

	initial begin
		#2_000_000;
		$display("tb: done, errors");
		$finish;
	end

	// one command transaction, after a random gap unless sends are steady
	task automatic send_event(input mode_t m, input logic [BYTE_W-1:0] b);
		int gap;
		gap = send_steady ? 0 : $urandom_range(0, MAX_WAIT);
		if (gap > 0) begin
			cmd_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd_ch.valid     <= 1'b1;
		cmd_ch.mode      <= m;
		cmd_ch.data_byte <= b;
		do @(posedge clk); while (!(cmd_ch.valid && cmd_ch.ready));
	endtask

	task automatic take_results();
		int stall;
		forever begin
			if ($urandom_range(0, 9) == 0) begin
				take_steady = !take_steady;
			end
			stall = take_steady ? 0 : $urandom_range(0, MAX_WAIT);
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
		end
	endtask

	// hold off commands until every target has been taken
	task automatic drain();
		cmd_ch.valid <= 1'b0;
		@(posedge clk);
		while (targets_pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
	endtask

	task automatic set_config(input logic [TRIM_W-1:0] pt, input logic [TRIM_W-1:0] rt,
			input logic [TRIM_W-1:0] yt, input logic [TRIM_W-1:0] tt,
			input logic [CFG_DATA_W-1:0] fv, input logic [AXES-1:0] fe,
			input logic [CFG_DATA_W-1:0] cm);
		write_reg(REG_PITCH_TRIM, CFG_DATA_W'(pt));
		write_reg(REG_ROLL_TRIM, CFG_DATA_W'(rt));
		write_reg(REG_YAW_TRIM, CFG_DATA_W'(yt));
		write_reg(REG_THROTTLE_TRIM, CFG_DATA_W'(tt));
		write_reg(REG_FALLBACK_VALUES, fv);
		write_reg(REG_FALLBACK_ENABLES, CFG_DATA_W'(fe));
		write_reg(REG_CHANNEL_MAP, cm);
		cfg_we <= 1'b0;
	endtask

	task automatic run_random(input int count);
		int  sent;
		int  pick;
		int  cut;
		int  k;
		bit  paused;
		sent   = 0;
		paused = 1'b0;
		while (sent < count) begin
			if ($urandom_range(0, 5) == 0) begin
				send_steady = !send_steady;
			end
			if (!paused && sent >= count / 2) begin
				paused = 1'b1;
				drain();
			end
			pick = $urandom_range(0, 9);
			case (pick)
				0, 1, 2, 3, 4: begin
					// control sequence, now and then broken by an event mid-payload
					cut = ($urandom_range(0, 3) == 0) ? $urandom_range(0, AXES - 1) : -1;
					send_event(MODE_CMD, CONTROL_OPCODE);
					for (k = 0; k < AXES; k++) begin
						if (k == cut) begin
							send_event($urandom_range(0, 1) ? MODE_FALLBACK : MODE_REVERT,
								BYTE_W'($urandom_range(0, 255)));
							sent++;
						end
						send_event(MODE_CMD, BYTE_W'($urandom_range(0, 255)));
					end
					sent += AXES + 1;
					if ($urandom_range(0, 1)) begin
						send_event(MODE_UPDATE, BYTE_W'($urandom_range(0, 255)));
						sent++;
					end
				end
				5: begin
					send_event(MODE_CMD, PARTY_OPCODE);
					send_event(MODE_UPDATE, BYTE_W'($urandom_range(0, 255)));
					sent += 2;
				end
				6: begin
					send_event($urandom_range(0, 1) ? MODE_FALLBACK : MODE_REVERT,
						BYTE_W'($urandom_range(0, 255)));
					sent++;
				end
				7: begin
					send_event(MODE_UPDATE, BYTE_W'($urandom_range(0, 255)));
					sent++;
				end
				default: begin
					// noise: not counted
					send_event(mode_t'($urandom_range(0, 3)), BYTE_W'($urandom_range(0, 255)));
				end
			endcase
		end
	endtask

	initial begin
		arst_n           <= 1'b0;
		cfg_we           <= 1'b0;
		cfg_index        <= '0;
		cfg_data         <= '0;
		cmd_ch.valid     <= 1'b0;
		cmd_ch.mode      <= MODE_CMD;
		cmd_ch.data_byte <= '0;
		res_ch.ready     <= 1'b0;
		send_steady      = 1'b0;
		take_steady      = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		fork
			take_results();
		join_none

		// reset values, then a full control sequence with extreme bytes
		send_event(MODE_UPDATE, 8'h00);
		send_event(MODE_CMD, CONTROL_OPCODE);
		send_event(MODE_CMD, 8'h00);
		send_event(MODE_CMD, 8'hFF);
		send_event(MODE_CMD, 8'h5A);
		send_event(MODE_CMD, 8'hA5);
		send_event(MODE_UPDATE, 8'hFF);
		// party zeroes yaw; unknown opcodes drop
		send_event(MODE_CMD, PARTY_OPCODE);
		send_event(MODE_CMD, 8'h7F);
		send_event(MODE_CMD, 8'hFF);
		send_event(MODE_UPDATE, 8'h00);
		// events inside a payload, opcode values as payload, repeated fallback
		send_event(MODE_CMD, CONTROL_OPCODE);
		send_event(MODE_CMD, 8'h33);
		send_event(MODE_FALLBACK, 8'h00);
		send_event(MODE_UPDATE, 8'h00);
		send_event(MODE_CMD, CONTROL_OPCODE);
		send_event(MODE_FALLBACK, 8'hFF);
		send_event(MODE_CMD, PARTY_OPCODE);
		send_event(MODE_CMD, 8'hC3);
		send_event(MODE_UPDATE, 8'h00);
		send_event(MODE_REVERT, 8'h00);
		send_event(MODE_REVERT, 8'hFF);
		send_event(MODE_UPDATE, 8'h00);
		drain();

		// trims at the range ends and beyond, no fallback loads
		set_config(9'h080, 9'h180, 9'h0FF, 9'h100, 32'hFF00_A55A, 4'h0, 32'hFF00_807F);
		run_random(RANDOM_PER_PHASE);
		drain();

		set_config(9'h1FF, 9'h001, 9'h000, 9'h07F, 32'h00FF_00FF, 4'h5, 32'h0F0E_0D0C);
		run_random(RANDOM_PER_PHASE);
		drain();

		set_config(TRIM_W'($urandom_range(0, 511)), TRIM_W'($urandom_range(0, 511)),
			TRIM_W'($urandom_range(0, 511)), TRIM_W'($urandom_range(0, 511)),
			CFG_DATA_W'($urandom()), AXES'($urandom_range(0, 15)), CFG_DATA_W'($urandom()));
		run_random(RANDOM_PER_PHASE);
		drain();
		repeat (8) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/scm_pkg.sv
rtl/scm_cmd_if.sv
rtl/scm_res_if.sv
rtl/scm_cfg_regs.sv
rtl/scm_axis_state.sv
rtl/scm_result_queue.sv
rtl/servo_command_mixer.sv
dv/servo_target_checker.sv
dv/tb.sv
